@@ hdl/otq_pkg.sv @@
// Shared types and constants for the ordered timer queue.
package otq_pkg;

  localparam int unsigned CMD_W          = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned ID_W           = 32;
  localparam int unsigned ENTRY_W        = TIME_W + ID_W;
  localparam int unsigned TIMER_SLOTS_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_SLEEP  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_WAIT = 2'd3
  } status_t;

  // One stored timer: expiry in the upper half, id in the lower half.
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   ident;
  } entry_t;

endpackage

@@ hdl/otq_slot_ram.sv @@
// Slot memory with one write port and one read port; the read data is registered.
module otq_slot_ram #(
  parameter int unsigned TIMER_SLOTS = otq_pkg::TIMER_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TIMER_SLOTS)-1:0] wr_addr,
  input  otq_pkg::entry_t                wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TIMER_SLOTS)-1:0] rd_addr,
  output otq_pkg::entry_t                rd_data
);
  import otq_pkg::*;

  entry_t mem [TIMER_SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/ordered_timer_queue_core.sv @@
// Ordered timer queue: slot table in memory, scanned one slot per cycle.
//
//   channel | ports                                           | handshake
//   input   | in_command in_delay_ms in_target_id in_now_ms   | start & !busy
//   result  | out_status out_timer_id out_time_value          | out_strobe
//
// Busy stays high while an item is scanned and finished: one memory read per slot via
// the single read port, a step for the last read data, and S_FINISH to write back.
// The result shows in the first cycle with busy low and the next item may enter at the
// end of that cycle, so no new item is taken before the last one's result shows.
// rst_n (synchronous) clears all valid bits and the id counter; no memory sweep.
// The receiver cannot stall: out_strobe is high for exactly one cycle per item.
module ordered_timer_queue_core #(
  parameter int unsigned TIMER_SLOTS = otq_pkg::TIMER_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [otq_pkg::CMD_W-1:0]     in_command,
  input  logic [otq_pkg::TIME_W-1:0]    in_delay_ms,
  input  logic [otq_pkg::ID_W-1:0]      in_target_id,
  input  logic [otq_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          out_strobe,
  output logic [otq_pkg::STATUS_W-1:0]  out_status,
  output logic [otq_pkg::ID_W-1:0]      out_timer_id,
  output logic [otq_pkg::TIME_W-1:0]    out_time_value
);
  import otq_pkg::*;

  localparam int unsigned IW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r;
  logic               rd_vld_r;
  logic [IW-1:0]      rd_idx_r;
  logic [TIMER_SLOTS-1:0] valid_r;
  logic [ID_W-1:0]    next_id_r;

  cmd_t               cmd_r;
  logic [TIME_W-1:0]  exp_r;
  logic [TIME_W-1:0]  now_r;
  logic [ID_W-1:0]    tgt_r;

  logic               found_r;
  logic [IW-1:0]      best_slot_r;
  logic [TIME_W-1:0]  best_exp_r;
  logic [ID_W-1:0]    best_id_r;
  logic               free_found_r;
  logic [IW-1:0]      free_slot_r;

  logic               out_strobe_r;
  status_t            out_status_r;
  logic [ID_W-1:0]    out_timer_id_r;
  logic [TIME_W-1:0]  out_time_value_r;

  // scan datapath
  entry_t             rd_data;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               ent_v;
  logic               earlier;
  logic               take;
  logic               take_free;
  logic               is_same;

  // write-back
  logic               wr_en;
  entry_t             wr_data;

  logic [TIME_W:0]    sum;

  assign sum     = {1'b0, in_now_ms} + {1'b0, in_delay_ms};
  assign rd_en   = (state_r == S_SCAN) && (cnt_r < CW'(TIMER_SLOTS));
  assign rd_addr = cnt_r[IW-1:0];

  assign wr_en   = (state_r == S_FINISH) && (cmd_r == CMD_ADD) && !found_r && free_found_r;
  assign wr_data = '{expiry: exp_r, ident: next_id_r};

  otq_slot_ram #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_slot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    ent_v     = rd_vld_r && valid_r[rd_idx_r];
    earlier   = {rd_data.expiry, rd_data.ident} < {best_exp_r, best_id_r};
    take      = 1'b0;
    take_free = 1'b0;
    is_same   = 1'b0;
    unique case (cmd_r)
      CMD_ADD: begin
        is_same   = ent_v && (rd_data.expiry == exp_r) && (rd_data.ident == next_id_r);
        take_free = rd_vld_r && !valid_r[rd_idx_r] && !free_found_r;
      end
      CMD_DELETE: begin
        take = ent_v && (rd_data.ident == tgt_r) && (!found_r || earlier);
      end
      CMD_CHECK, CMD_SLEEP: begin
        take = ent_v && (!found_r || earlier);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      next_id_r    <= '0;
      out_strobe_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      cnt_r        <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      rd_vld_r     <= rd_en;
      rd_idx_r     <= rd_addr;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r        <= cmd_t'(in_command);
            // saturate the expiry on carry out
            exp_r        <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            now_r        <= in_now_ms;
            tgt_r        <= in_target_id;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            cnt_r        <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r < CW'(TIMER_SLOTS)) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_FINISH;
          end
          if (take) begin
            found_r     <= 1'b1;
            best_slot_r <= rd_idx_r;
            best_exp_r  <= rd_data.expiry;
            best_id_r   <= rd_data.ident;
          end
          if (is_same) begin
            found_r <= 1'b1;
          end
          if (take_free) begin
            free_found_r <= 1'b1;
            free_slot_r  <= rd_idx_r;
          end
        end
        S_FINISH: begin
          out_strobe_r     <= 1'b1;
          out_status_r     <= ST_NONE;
          out_timer_id_r   <= '0;
          out_time_value_r <= '0;
          unique case (cmd_r)
            CMD_ADD: begin
              if (found_r || free_found_r) begin
                out_status_r     <= ST_DONE;
                out_timer_id_r   <= next_id_r;
                out_time_value_r <= exp_r;
                next_id_r        <= next_id_r + 1'b1;
                if (!found_r) begin
                  valid_r[free_slot_r] <= 1'b1;
                end
              end else begin
                out_status_r <= ST_FULL;
              end
            end
            CMD_DELETE: begin
              if (found_r) begin
                valid_r[best_slot_r] <= 1'b0;
                out_status_r         <= ST_DONE;
                out_timer_id_r       <= tgt_r;
              end
            end
            CMD_CHECK: begin
              if (found_r) begin
                if (best_exp_r < now_r) begin
                  valid_r[best_slot_r] <= 1'b0;
                  out_status_r         <= ST_DONE;
                  out_timer_id_r       <= best_id_r;
                end else begin
                  out_status_r <= ST_WAIT;
                end
              end
            end
            CMD_SLEEP: begin
              if (found_r) begin
                out_status_r     <= ST_DONE;
                out_timer_id_r   <= best_id_r;
                out_time_value_r <= (best_exp_r > now_r) ? best_exp_r - now_r : '0;
              end
            end
            default: begin
              out_status_r <= ST_NONE;
            end
          endcase
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_timer_id   = out_timer_id_r;
  assign out_time_value = out_time_value_r;

endmodule
